### rtl/hgsa_pkg.sv
// ----------------------------------------------------------------------------
// hgsa_pkg
// Shared constants, result codes and controller/datapath interface types for
// the hash group-by sum aggregator.
// ----------------------------------------------------------------------------
package hgsa_pkg;

  localparam int unsigned MAX_SLOTS = 1024;
  localparam int unsigned ADDR_W    = $clog2(MAX_SLOTS);
  localparam int unsigned KEY_W     = 32;
  localparam int unsigned SUM_W     = 32;
  localparam int unsigned SLOT_W    = 10;
  localparam int unsigned TB_W      = 4;
  localparam int unsigned STATUS_W  = 3;

  // clog2(MAX_SLOTS), upper limit of the active bit count
  localparam logic [TB_W-1:0] MAX_BITS  = TB_W'(ADDR_W);
  localparam logic [TB_W-1:0] MIN_BITS  = TB_W'(1);
  localparam logic [TB_W-1:0] RESET_TB  = TB_W'(10);

  localparam logic [KEY_W-1:0] HASH_MULT = 32'd2191554561;

  typedef enum logic [STATUS_W-1:0] {
    STS_ADDED    = 3'd0,
    STS_INSERTED = 3'd1,
    STS_FULL     = 3'd2,
    STS_ZERO_KEY = 3'd3,
    STS_READ     = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    RES_UPDATE = 2'd0,
    RES_FULL   = 2'd1,
    RES_ZERO   = 2'd2,
    RES_READ   = 2'd3
  } res_sel_e;

  typedef struct packed {
    logic     clr_wr;
    logic     capture;
    logic     rd_home;
    logic     rd_next;
    logic     wr_entry;
    logic     load_out;
    res_sel_e res_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic in_is_read;
    logic in_key_zero;
    logic hit;
    logic empty;
    logic probe_done;
    logic out_free;
  } dp_sts_t;

endpackage

### rtl/hgsa_dp.sv
// ----------------------------------------------------------------------------
// hgsa_dp
// Datapath: slot table memory, hash multiplier, probe address and counter,
// clear sweep counter and the result output register.
// ----------------------------------------------------------------------------
module hgsa_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  hgsa_pkg::dp_cmd_t              cmd_i,
  output hgsa_pkg::dp_sts_t              sts_o,
  input  logic [hgsa_pkg::TB_W-1:0]      bits_i,
  input  logic                           kind_i,
  input  logic [hgsa_pkg::KEY_W-1:0]     group_key_i,
  input  logic signed [hgsa_pkg::SUM_W-1:0] add_value_i,
  input  logic [hgsa_pkg::SLOT_W-1:0]    slot_index_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [hgsa_pkg::STATUS_W-1:0]  status_o,
  output logic [hgsa_pkg::SLOT_W-1:0]    slot_o,
  output logic [hgsa_pkg::KEY_W-1:0]     entry_key_o,
  output logic signed [hgsa_pkg::SUM_W-1:0] entry_sum_o
);

  typedef struct packed {
    logic [hgsa_pkg::KEY_W-1:0] key;
    logic [hgsa_pkg::SUM_W-1:0] sum;
  } entry_t;

  entry_t mem [hgsa_pkg::MAX_SLOTS];

  entry_t                        rd_q;
  logic [hgsa_pkg::KEY_W-1:0]    key_q;
  logic [hgsa_pkg::SUM_W-1:0]    val_q;
  logic [hgsa_pkg::KEY_W-1:0]    prod_q;
  logic [hgsa_pkg::ADDR_W-1:0]   addr_q, addr_d;
  logic [hgsa_pkg::ADDR_W-1:0]   home_q;
  logic [hgsa_pkg::ADDR_W-1:0]   cnt_q;
  logic [hgsa_pkg::ADDR_W-1:0]   clr_cnt_q;

  logic                          out_valid_q;
  hgsa_pkg::status_e             status_q;
  logic [hgsa_pkg::SLOT_W-1:0]   slot_q;
  logic [hgsa_pkg::KEY_W-1:0]    okey_q;
  logic [hgsa_pkg::SUM_W-1:0]    osum_q;

  logic [hgsa_pkg::KEY_W-1:0]    hash_prod;
  logic [hgsa_pkg::ADDR_W-1:0]   mask;
  logic [hgsa_pkg::TB_W-1:0]     shamt;
  logic [hgsa_pkg::ADDR_W-1:0]   home;
  logic [hgsa_pkg::ADDR_W-1:0]   rd_idx;
  logic [hgsa_pkg::ADDR_W-1:0]   next_addr;
  logic [hgsa_pkg::SUM_W-1:0]    new_sum;
  logic                          rd_en;
  logic                          wr_en;
  logic [hgsa_pkg::ADDR_W-1:0]   wr_addr;
  entry_t                        wr_data;
  logic                          hit;
  logic                          empty;

  // active table mask and home slot from the registered hash product
  assign mask      = ~({hgsa_pkg::ADDR_W{1'b1}} << bits_i);
  assign shamt     = hgsa_pkg::MAX_BITS - bits_i;
  assign hash_prod = group_key_i * hgsa_pkg::HASH_MULT;
  assign home      = prod_q[hgsa_pkg::KEY_W-1 -: hgsa_pkg::ADDR_W] >> shamt;
  assign rd_idx    = hgsa_pkg::ADDR_W'(slot_index_i) & mask;
  assign next_addr = (addr_q + hgsa_pkg::ADDR_W'(1)) & mask;

  assign hit     = (rd_q.key == key_q);
  assign empty   = (rd_q.key == '0);
  assign new_sum = hit ? (rd_q.sum + val_q) : val_q;

  always_comb begin
    addr_d = addr_q;
    rd_en  = 1'b0;
    priority if (cmd_i.capture) begin
      addr_d = rd_idx;
      rd_en  = 1'b1;
    end else if (cmd_i.rd_home) begin
      addr_d = home;
      rd_en  = 1'b1;
    end else if (cmd_i.rd_next) begin
      addr_d = next_addr;
      rd_en  = 1'b1;
    end
  end

  assign wr_en   = cmd_i.clr_wr | cmd_i.wr_entry;
  assign wr_addr = cmd_i.clr_wr ? clr_cnt_q : addr_q;
  assign wr_data = cmd_i.clr_wr ? entry_t'('0) : entry_t'({key_q, new_sum});

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q <= mem[addr_d];
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    if (cmd_i.capture) begin
      key_q  <= group_key_i;
      val_q  <= add_value_i;
      prod_q <= hash_prod;
    end
    if (cmd_i.rd_home) begin
      home_q <= home;
      cnt_q  <= '0;
    end else if (cmd_i.rd_next) begin
      cnt_q  <= cnt_q + hgsa_pkg::ADDR_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_wr) begin
      clr_cnt_q <= clr_cnt_q + hgsa_pkg::ADDR_W'(1);
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      unique case (cmd_i.res_sel)
        hgsa_pkg::RES_UPDATE: begin
          status_q <= hit ? hgsa_pkg::STS_ADDED : hgsa_pkg::STS_INSERTED;
          slot_q   <= hgsa_pkg::SLOT_W'(addr_q);
          okey_q   <= key_q;
          osum_q   <= new_sum;
        end
        hgsa_pkg::RES_FULL: begin
          status_q <= hgsa_pkg::STS_FULL;
          slot_q   <= hgsa_pkg::SLOT_W'(home_q);
          okey_q   <= '0;
          osum_q   <= '0;
        end
        hgsa_pkg::RES_ZERO: begin
          status_q <= hgsa_pkg::STS_ZERO_KEY;
          slot_q   <= '0;
          okey_q   <= '0;
          osum_q   <= '0;
        end
        hgsa_pkg::RES_READ: begin
          status_q <= hgsa_pkg::STS_READ;
          slot_q   <= hgsa_pkg::SLOT_W'(addr_q);
          okey_q   <= rd_q.key;
          osum_q   <= rd_q.sum;
        end
        default: begin
          status_q <= hgsa_pkg::STS_READ;
          slot_q   <= '0;
          okey_q   <= '0;
          osum_q   <= '0;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign slot_o      = slot_q;
  assign entry_key_o = okey_q;
  assign entry_sum_o = signed'(osum_q);

  assign sts_o.clr_last    = (clr_cnt_q == {hgsa_pkg::ADDR_W{1'b1}});
  assign sts_o.in_is_read  = kind_i;
  assign sts_o.in_key_zero = (group_key_i == '0);
  assign sts_o.hit         = hit;
  assign sts_o.empty       = empty;
  assign sts_o.probe_done  = (cnt_q == mask);
  assign sts_o.out_free    = !out_valid_q || out_ready_i;

endmodule

### rtl/hgsa_ctrl.sv
// ----------------------------------------------------------------------------
// hgsa_ctrl
// Controller: clear sweep after reset, item accept, probe sequencing and
// result hand-off to the output register.
// ----------------------------------------------------------------------------
module hgsa_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  hgsa_pkg::dp_sts_t  sts_i,
  output hgsa_pkg::dp_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HOME,
    S_CHECK,
    S_EMIT_READ,
    S_EMIT_ZERO
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.res_sel = hgsa_pkg::RES_UPDATE;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          cmd_o.capture = 1'b1;
          priority if (sts_i.in_is_read) begin
            state_d = S_EMIT_READ;
          end else if (sts_i.in_key_zero) begin
            state_d = S_EMIT_ZERO;
          end else begin
            state_d = S_HOME;
          end
        end
      end
      S_HOME: begin
        cmd_o.rd_home = 1'b1;
        state_d       = S_CHECK;
      end
      S_CHECK: begin
        priority if (sts_i.hit || sts_i.empty) begin
          if (sts_i.out_free) begin
            cmd_o.wr_entry = 1'b1;
            cmd_o.load_out = 1'b1;
            cmd_o.res_sel  = hgsa_pkg::RES_UPDATE;
            state_d        = S_IDLE;
          end
        end else if (sts_i.probe_done) begin
          if (sts_i.out_free) begin
            cmd_o.load_out = 1'b1;
            cmd_o.res_sel  = hgsa_pkg::RES_FULL;
            state_d        = S_IDLE;
          end
        end else begin
          cmd_o.rd_next = 1'b1;
        end
      end
      S_EMIT_READ: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.res_sel  = hgsa_pkg::RES_READ;
          state_d        = S_IDLE;
        end
      end
      S_EMIT_ZERO: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.res_sel  = hgsa_pkg::RES_ZERO;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // entry writes only land on a matching or empty slot with room for the result
  a_wr_on_hit_or_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.wr_entry |-> ((sts_i.hit || sts_i.empty) && sts_i.out_free))
    else $error("entry write without hit or empty slot");

  // a result is never loaded over one that has not been taken
  a_load_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> sts_i.out_free)
    else $error("result register overwritten");

  // the probe never steps on once every slot of the active table has been read
  a_no_probe_past_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd_next |-> !sts_i.probe_done)
    else $error("probe stepped past full table");

  // no item is taken during the clear sweep
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.clr_wr |-> !cmd_o.capture))
    else $error("item accepted during clear");

endmodule

### rtl/hash_group_sum_aggregator.sv
// ----------------------------------------------------------------------------
// hash_group_sum_aggregator
// Group-by sum engine on an open-addressing table with linear probing.
//
//   channel   signals                                   direction
//   in        in_valid_i / in_ready_o, kind_i,          in
//             group_key_i, add_value_i, slot_index_i
//   out       out_valid_o / out_ready_i, status_o,      out
//             slot_o, entry_key_o, entry_sum_o
//   cfg       cfg_we_i, cfg_wdata_i (table_bits)        in
//
// read and zero-key items pass from capture straight to the result register;
// accumulate items read the home slot, then one further slot per probe step,
// each a registered read of the slot table; after reset the table is cleared
// one slot a cycle, in_ready_o low; configuration writes are taken throughout
// one item is in flight at a time; a held result stalls the item behind it
// ----------------------------------------------------------------------------
module hash_group_sum_aggregator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              kind_i,
  input  logic [hgsa_pkg::KEY_W-1:0]        group_key_i,
  input  logic signed [hgsa_pkg::SUM_W-1:0] add_value_i,
  input  logic [hgsa_pkg::SLOT_W-1:0]       slot_index_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [hgsa_pkg::STATUS_W-1:0]     status_o,
  output logic [hgsa_pkg::SLOT_W-1:0]       slot_o,
  output logic [hgsa_pkg::KEY_W-1:0]        entry_key_o,
  output logic signed [hgsa_pkg::SUM_W-1:0] entry_sum_o,
  input  logic                              cfg_we_i,
  input  logic [hgsa_pkg::TB_W-1:0]         cfg_wdata_i
);

  logic [hgsa_pkg::TB_W-1:0] table_bits_q;
  logic [hgsa_pkg::TB_W-1:0] bits_act;
  hgsa_pkg::dp_cmd_t         cmd;
  hgsa_pkg::dp_sts_t         sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_bits_q <= hgsa_pkg::RESET_TB;
    end else if (cfg_we_i) begin
      table_bits_q <= cfg_wdata_i;
    end
  end

  // saturate the table size to the supported range
  always_comb begin
    priority if (table_bits_q < hgsa_pkg::MIN_BITS) begin
      bits_act = hgsa_pkg::MIN_BITS;
    end else if (table_bits_q > hgsa_pkg::MAX_BITS) begin
      bits_act = hgsa_pkg::MAX_BITS;
    end else begin
      bits_act = table_bits_q;
    end
  end

  hgsa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  hgsa_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .bits_i       (bits_act),
    .kind_i       (kind_i),
    .group_key_i  (group_key_i),
    .add_value_i  (add_value_i),
    .slot_index_i (slot_index_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .slot_o       (slot_o),
    .entry_key_o  (entry_key_o),
    .entry_sum_o  (entry_sum_o)
  );

endmodule

### verif/hash_group_sum_aggregator_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hash_group_sum_aggregator_test
// Self-checking bench for the group-by sum engine. A shadow copy of the slot
// table predicts every result from the accepted input items. The stimulus is
// a directed opening on the full-size and two-slot tables, then random phases, each with
// its own size and key pool, under bursty input and a stalling output side.
// ----------------------------------------------------------------------------
module hash_group_sum_aggregator_test;

  localparam int STALL_LIMIT  = 10000;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_ITEMS  = 108;

  typedef struct packed {
    hgsa_pkg::status_e                 status;
    logic [hgsa_pkg::SLOT_W-1:0]       slot;
    logic [hgsa_pkg::KEY_W-1:0]        key;
    logic [hgsa_pkg::SUM_W-1:0]        sum;
  } agg_result_t;

  class group_sum_tracker;
    logic [hgsa_pkg::KEY_W-1:0] shadow_key [hgsa_pkg::MAX_SLOTS];
    logic [hgsa_pkg::SUM_W-1:0] shadow_sum [hgsa_pkg::MAX_SLOTS];
    logic [hgsa_pkg::TB_W-1:0]  table_bits;
    agg_result_t                awaited[$];
    int unsigned                mismatches;

    function new();
      foreach (shadow_key[i]) begin
        shadow_key[i] = '0;
        shadow_sum[i] = '0;
      end
      table_bits = hgsa_pkg::RESET_TB;
      mismatches = 0;
    endfunction

    function int unsigned active_bits();
      if (table_bits < hgsa_pkg::MIN_BITS) return hgsa_pkg::MIN_BITS;
      if (table_bits > hgsa_pkg::MAX_BITS) return hgsa_pkg::MAX_BITS;
      return table_bits;
    endfunction

    function int unsigned outstanding();
      return awaited.size();
    endfunction

    // work out the slot update and the result for one accepted item
    function void note_item(input logic kind,
                            input logic [hgsa_pkg::KEY_W-1:0] key,
                            input logic [hgsa_pkg::SUM_W-1:0] val,
                            input logic [hgsa_pkg::SLOT_W-1:0] idx);
      int unsigned                 nbits;
      logic [hgsa_pkg::SLOT_W-1:0] mask;
      logic [hgsa_pkg::SLOT_W-1:0] home;
      logic [hgsa_pkg::SLOT_W-1:0] s;
      logic [hgsa_pkg::KEY_W-1:0]  prod;
      agg_result_t                 r;
      int unsigned                 j;
      bit                          done;
      nbits = active_bits();
      mask  = hgsa_pkg::SLOT_W'((1 << nbits) - 1);
      prod  = key * hgsa_pkg::HASH_MULT;
      home  = hgsa_pkg::SLOT_W'(prod >> (hgsa_pkg::KEY_W - nbits));
      r.status = hgsa_pkg::STS_ZERO_KEY;
      r.slot   = '0;
      r.key    = '0;
      r.sum    = '0;
      if (kind) begin
        s = idx & mask;
        r.status = hgsa_pkg::STS_READ;
        r.slot   = s;
        r.key    = shadow_key[s];
        r.sum    = shadow_sum[s];
      end else if (key != '0) begin
        r.status = hgsa_pkg::STS_FULL;
        r.slot   = home;
        done = 1'b0;
        for (j = 0; j <= mask && !done; j++) begin
          s = (home + hgsa_pkg::SLOT_W'(j)) & mask;
          if (shadow_key[s] == key) begin
            shadow_sum[s] = shadow_sum[s] + val;
            r.status = hgsa_pkg::STS_ADDED;
            r.slot   = s;
            r.key    = key;
            r.sum    = shadow_sum[s];
            done = 1'b1;
          end else if (shadow_key[s] == '0) begin
            shadow_key[s] = key;
            shadow_sum[s] = val;
            r.status = hgsa_pkg::STS_INSERTED;
            r.slot   = s;
            r.key    = key;
            r.sum    = val;
            done = 1'b1;
          end
        end
      end
      awaited = {awaited, r};
    endfunction

    function void check_result(input logic [hgsa_pkg::STATUS_W-1:0] act_status,
                               input logic [hgsa_pkg::SLOT_W-1:0] act_slot,
                               input logic [hgsa_pkg::KEY_W-1:0] act_key,
                               input logic [hgsa_pkg::SUM_W-1:0] act_sum);
      agg_result_t exp_r;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d slot %0d key %h sum %h",
                   act_status, act_slot, act_key, act_sum);
      end else begin
        exp_r = awaited.pop_front();
        if (exp_r.status !== act_status || exp_r.slot !== act_slot ||
            exp_r.key !== act_key || exp_r.sum !== act_sum) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp status %0d slot %0d key %h sum %h, %s",
                     exp_r.status, exp_r.slot, exp_r.key, exp_r.sum,
                     $sformatf("got status %0d slot %0d key %h sum %h",
                               act_status, act_slot, act_key, act_sum));
        end
      end
    endfunction
  endclass

  logic                                clk_i;
  logic                                rst_ni;
  logic                                in_valid_i;
  logic                                in_ready_o;
  logic                                kind_i;
  logic [hgsa_pkg::KEY_W-1:0]          group_key_i;
  logic signed [hgsa_pkg::SUM_W-1:0]   add_value_i;
  logic [hgsa_pkg::SLOT_W-1:0]         slot_index_i;
  logic                                out_valid_o;
  logic                                out_ready_i;
  logic [hgsa_pkg::STATUS_W-1:0]       status_o;
  logic [hgsa_pkg::SLOT_W-1:0]         slot_o;
  logic [hgsa_pkg::KEY_W-1:0]          entry_key_o;
  logic signed [hgsa_pkg::SUM_W-1:0]   entry_sum_o;
  logic                                cfg_we_i;
  logic [hgsa_pkg::TB_W-1:0]           cfg_wdata_i;

  group_sum_tracker          tracker = new();
  int                        hold_requests = 0;
  int                        idle_cycles = 0;
  logic [hgsa_pkg::TB_W-1:0] phase_bits [12] = '{4'd2, 4'd3, 4'd5, 4'd10, 4'd4, 4'd7,
                                                 4'd1, 4'd8, 4'd12, 4'd6, 4'd9, 4'd10};

  hash_group_sum_aggregator u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .group_key_i  (group_key_i),
    .add_value_i  (add_value_i),
    .slot_index_i (slot_index_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .slot_o       (slot_o),
    .entry_key_o  (entry_key_o),
    .entry_sum_o  (entry_sum_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o)
      tracker.note_item(kind_i, group_key_i, add_value_i, slot_index_i);
    if (rst_ni && out_valid_o && out_ready_i)
      tracker.check_result(status_o, slot_o, entry_key_o, entry_sum_o);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL hash_group_sum_aggregator");
      $finish;
    end
  end

  // output side: stretches of differing ready patterns, one long hold-off on request
  initial begin
    int mode;
    int len;
    int k;
    int holds_done;
    holds_done = 0;
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_requests != holds_done) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        holds_done = hold_requests;
      end
      mode = $urandom_range(0, 3);
      len  = $urandom_range(4, 48);
      for (k = 0; k < len; k++) begin
        case (mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= 1'($urandom_range(0, 1));
          2: out_ready_i <= (k % 4 == 0);
          default: out_ready_i <= (k % 3 != 2);
        endcase
        @(posedge clk_i);
      end
    end
  end

  task automatic send_item(input logic kind, input logic [hgsa_pkg::KEY_W-1:0] key,
                           input logic [hgsa_pkg::SUM_W-1:0] val,
                           input logic [hgsa_pkg::SLOT_W-1:0] idx);
    in_valid_i   <= 1'b1;
    kind_i       <= kind;
    group_key_i  <= key;
    add_value_i  <= val;
    slot_index_i <= idx;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
  endtask

  // sender pauses until every outstanding item has produced its result
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (tracker.outstanding() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_table_bits(input logic [hgsa_pkg::TB_W-1:0] bits);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= bits;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.table_bits = bits;
  endtask

  task automatic random_phase(input logic [hgsa_pkg::TB_W-1:0] bits, input int n_items,
                              input int hold_at);
    logic [hgsa_pkg::KEY_W-1:0]  pool [40];
    int                          pool_n;
    int unsigned                 size;
    int                          i;
    int                          burst_left;
    int                          gap;
    int                          roll;
    logic                        kind;
    logic [hgsa_pkg::KEY_W-1:0]  key;
    logic [hgsa_pkg::SUM_W-1:0]  val;
    logic [hgsa_pkg::SLOT_W-1:0] idx;
    write_table_bits(bits);
    size = 1 << tracker.active_bits();
    // small tables get a pool just over their size so they run full
    pool_n = (size <= 8) ? int'(size) + 2 : $urandom_range(12, 40);
    for (i = 0; i < pool_n; i++) begin
      pool[i] = $urandom;
      if (pool[i] == '0) pool[i] = 32'h1;
    end
    burst_left = $urandom_range(1, 24);
    for (i = 0; i < n_items; i++) begin
      if (i == hold_at) hold_requests++;
      roll = $urandom_range(0, 99);
      kind = (roll < 22);
      idx  = hgsa_pkg::SLOT_W'($urandom);
      if (roll < 22) key = $urandom;
      else if (roll < 25) key = '0;
      else if (roll < 30) key = $urandom;
      else key = pool[$urandom_range(0, pool_n - 1)];
      case ($urandom_range(0, 9))
        0: begin
          case ($urandom_range(0, 3))
            0: val = 32'h7fff_ffff;
            1: val = 32'h8000_0000;
            2: val = 32'hffff_ffff;
            default: val = '0;
          endcase
        end
        1, 2: val = hgsa_pkg::SUM_W'($signed($urandom_range(0, 31)) - 16);
        default: val = $urandom;
      endcase
      send_item(kind, key, val, idx);
      burst_left--;
      if (burst_left <= 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        if (gap > 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        burst_left = $urandom_range(1, 24);
      end
    end
    drain();
  endtask

  initial begin
    in_valid_i   <= 1'b0;
    kind_i       <= 1'b0;
    group_key_i  <= '0;
    add_value_i  <= '0;
    slot_index_i <= '0;
    cfg_we_i     <= 1'b0;
    cfg_wdata_i  <= '0;
    rst_ni       <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // full-size table straight out of reset: zero key, wrapping sums, reads
    send_item(1'b0, 32'h0000_0000, 32'h0000_0005, 10'd0);
    send_item(1'b0, 32'h0000_0001, 32'h7fff_ffff, 10'd0);
    send_item(1'b0, 32'h0000_0001, 32'h0000_0001, 10'd0);
    send_item(1'b0, 32'hffff_ffff, 32'h8000_0000, 10'h3ff);
    send_item(1'b0, 32'hffff_ffff, 32'hffff_ffff, 10'h3ff);
    send_item(1'b1, 32'hdead_beef, 32'h0000_0000, 10'd0);
    send_item(1'b1, 32'h0000_0000, 32'hffff_ffff, 10'h3ff);
    send_item(1'b1, 32'h0000_0000, 32'h0000_0000, 10'h155);
    send_item(1'b1, 32'hffff_ffff, 32'h7fff_ffff, 10'h2aa);
    drain();

    // two-slot table: fill it, overflow it, wrap read indexes
    write_table_bits(4'd1);
    send_item(1'b0, 32'ha5a5_a5a5, 32'hffff_ffff, 10'd0);
    send_item(1'b0, 32'h1234_5678, 32'h0000_0007, 10'd0);
    send_item(1'b0, 32'h0bad_f00d, 32'h0000_0003, 10'd0);
    send_item(1'b0, 32'ha5a5_a5a5, 32'h0000_0001, 10'd0);
    send_item(1'b1, 32'h0000_0000, 32'h0000_0000, 10'h3ff);
    send_item(1'b1, 32'h0000_0000, 32'h0000_0000, 10'd2);
    send_item(1'b0, 32'h0000_0000, 32'h7fff_ffff, 10'h3ff);
    drain();

    // out-of-range sizes saturate at both ends
    write_table_bits(4'd0);
    send_item(1'b0, 32'h1234_5678, 32'h8000_0000, 10'd0);
    send_item(1'b1, 32'h0000_0000, 32'h0000_0000, 10'h3ff);
    drain();
    write_table_bits(4'd15);
    send_item(1'b1, 32'h0000_0000, 32'h0000_0000, 10'h3ff);
    send_item(1'b0, 32'h1234_5678, 32'h0000_0001, 10'd0);
    drain();

    foreach (phase_bits[p])
      random_phase(phase_bits[p], PHASE_ITEMS, (p == 3) ? 15 : -1);

    repeat (100) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
      $display("PASS hash_group_sum_aggregator");
    end else begin
      $display("FAIL hash_group_sum_aggregator");
    end
    $finish;
  end

endmodule
